/* sv/qs_pkg.sv */
// Shared types, constants and arctangent table for the quaternion slerp datapath.
package qs_pkg;

  localparam int AW  = 20;
  localparam int CW  = 32;
  localparam int SQW = 57;
  localparam int DW  = 32;

  localparam int ONE_Q14     = 16384;
  localparam int ONE_Q28     = 268435456;
  localparam int PI_Q14      = 51472;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int GAIN_Q28    = 163008218;

  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    ang_t  z;
  } cordic_t;

  typedef struct packed {
    logic       pass;
    logic [3:0] neg;
    logic [3:0] ovf;
  } st_t;

  function automatic ang_t atan_q16(input int k);
    ang_t r;
    case (k)
      0:       r = AW'(51472);
      1:       r = AW'(30386);
      2:       r = AW'(16055);
      3:       r = AW'(8150);
      4:       r = AW'(4091);
      5:       r = AW'(2047);
      6:       r = AW'(1024);
      7:       r = AW'(512);
      8:       r = AW'(256);
      9:       r = AW'(128);
      10:      r = AW'(64);
      11:      r = AW'(32);
      12:      r = AW'(16);
      13:      r = AW'(8);
      14:      r = AW'(4);
      15:      r = AW'(2);
      16:      r = AW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/qs_sqrt_cell.sv */
// One digit step of the integer square root chain.
module qs_sqrt_cell #(
  parameter int BITPOS = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [qs_pkg::SQW-1:0] v_i,
  input  logic [qs_pkg::SQW-1:0] r_i,
  output logic [qs_pkg::SQW-1:0] v_o,
  output logic [qs_pkg::SQW-1:0] r_o
);
  import qs_pkg::*;

  logic [SQW-1:0] bit_c;
  logic [SQW:0]   trial;
  logic           take;
  logic [SQW-1:0] v_nxt;
  logic [SQW-1:0] r_nxt;
  logic [SQW-1:0] v_r;
  logic [SQW-1:0] r_r;

  always_comb begin
    bit_c = SQW'(1) << BITPOS;
    trial = {1'b0, r_i} + {1'b0, bit_c};
    take  = {1'b0, v_i} >= trial;
    if (take) begin
      v_nxt = v_i - trial[SQW-1:0];
      r_nxt = (r_i >> 1) + bit_c;
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;

endmodule

/* sv/qs_cordic_cell.sv */
// One CORDIC micro-rotation, vectoring or rotation mode.
module qs_cordic_cell #(
  parameter int STAGE     = 0,
  parameter bit VECTORING = 1'b1
) (
  input  logic            clk,
  input  logic            en,
  input  qs_pkg::cordic_t c_i,
  output qs_pkg::cordic_t c_o
);
  import qs_pkg::*;

  cval_t   dx;
  cval_t   dy;
  logic    add;
  cordic_t c_nxt;
  cordic_t c_r;

  always_comb begin
    dx  = c_i.y >>> STAGE;
    dy  = c_i.x >>> STAGE;
    add = VECTORING ? ~c_i.y[CW-1] : c_i.z[AW-1];
    if (add) begin
      c_nxt.x = c_i.x + dx;
      c_nxt.y = c_i.y - dy;
      c_nxt.z = c_i.z + atan_q16(STAGE);
    end else begin
      c_nxt.x = c_i.x - dx;
      c_nxt.y = c_i.y + dy;
      c_nxt.z = c_i.z - atan_q16(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_o = c_r;

endmodule

/* sv/qs_div_cell.sv */
// One quotient bit of the restoring divider chain.
module qs_div_cell #(
  parameter int NW    = 49,
  parameter int QW    = 16,
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [NW-1:0]         rem_i,
  input  logic [qs_pkg::DW-1:0] dvs_i,
  input  logic [QW-1:0]         q_i,
  output logic [NW-1:0]         rem_o,
  output logic [qs_pkg::DW-1:0] dvs_o,
  output logic [QW-1:0]         q_o
);
  import qs_pkg::*;

  logic [NW-1:0] sh;
  logic [NW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;
  logic [NW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [QW-1:0] q_r;

  always_comb begin
    sh = NW'(dvs_i) << SHIFT;
    if (rem_i >= sh) begin
      rem_nxt = rem_i - sh;
      q_nxt   = q_i | (QW'(1) << SHIFT);
    end else begin
      rem_nxt = rem_i;
      q_nxt   = q_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_i;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign dvs_o = dvs_r;
  assign q_o   = q_r;

endmodule

/* sv/quaternion_slerp.sv */
// Quaternion slerp top level: dot product, root, CORDIC angle, sine lanes, divider chain.
// Fully pipelined: one transaction is taken every cycle unless the pipe holds.
// The pipe length is set by the cell chains: 29 square-root cells, a vectoring
// CORDIC chain followed by three parallel rotation chains of CORDIC_STAGES cells
// each, and one divider cell per result bit. The whole pipe holds only while a
// finished result sits at the output under stall.
module quaternion_slerp #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [10:0]                       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_src_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_src_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_src_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_src_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dst_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dst_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dst_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dst_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_blend,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] out_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_z,
  output logic signed [COMPONENT_WIDTH-1:0] out_w,
  output logic                              out_passed_through
);
  import qs_pkg::*;

  localparam int W     = COMPONENT_WIDTH;
  localparam int C     = CORDIC_STAGES;
  localparam int DPW   = (2 * W + 2 > 30) ? 2 * W + 2 : 30;
  localparam int PW    = CW + W;
  localparam int NW    = CW + W + 1;
  localparam int SDW   = 8 * W + 15;
  localparam int SQ_N  = 29;
  localparam int ST_P  = 4 + SQ_N;
  localparam int ST_A  = ST_P + C + 1;
  localparam int ST_M  = ST_A + 1;
  localparam int ST_R  = ST_M + 1;
  localparam int ST_D  = ST_R + C + 1;
  localparam int ST_N  = ST_D + 1;
  localparam int ST_V  = ST_N + 1;
  localparam int ST_O  = ST_V + 1;
  localparam int ST_F  = ST_O + W + 1;
  localparam int L     = ST_F + 1;

  function automatic ang_t fold(input logic [17:0] v);
    ang_t r;
    r = $signed(AW'(v));
    if (v > 18'(HALF_PI_Q16)) begin
      r = ang_t'(PI_Q16) - r;
    end
    return r;
  endfunction

  logic                  adv;
  logic [L-1:0]          vld_r;
  logic [10:0]           tol_r;

  logic [SDW-1:0]        sd_r [0:ST_F-1];
  logic [14:0]           t_c;
  logic signed [32:0]    t_ext;
  logic signed [2*W-1:0] prod_r [4];
  logic signed [DPW-1:0] dsum;
  logic signed [DPW-1:0] dclp;
  logic signed [29:0]    dot_r [1:ST_P-1];
  logic signed [59:0]    sqf;
  logic [SQW-1:0]        sq_r;
  logic [SQW-1:0]        rem_r;
  logic [SQW-1:0]        v_w [SQ_N+1];
  logic [SQW-1:0]        r_w [SQ_N+1];
  cordic_t               p_r;
  cordic_t               vec_w [C+1];
  ang_t                  zc;
  logic [15:0]           a_r;
  logic [32:0]           pa_r;
  logic [32:0]           pb_r;
  logic [17:0]           a16_r;
  logic                  near;
  logic [17:0]           ta;
  logic [17:0]           tb;
  cordic_t               rot0_r [3];
  cordic_t               rot_w [3][C+1];
  st_t                   st_r [ST_M:ST_F-1];
  cval_t                 sa_d_r;
  cval_t                 sa_n_r;
  cval_t                 sa_v_r;
  cval_t                 sa_o_r;
  logic signed [PW-1:0]  p0_r [4];
  logic signed [PW-1:0]  p1_r [4];
  logic signed [PW:0]    num_r [4];
  logic [NW-1:0]         nv_r [4];
  logic [3:0]            neg_c;
  logic [3:0]            ovf_c;
  logic [NW-1:0]         dvr_r [4];
  logic [NW-1:0]         drem_w [4][W+1];
  logic [DW-1:0]         ddvs_w [4][W+1];
  logic [W-1:0]          dq_w [4][W+1];
  logic [W-1:0]          o_r [4];
  logic                  pt_r;

  assign adv      = ~(vld_r[L-1] & out_stall);
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      tol_r <= 11'd16;
    end else begin
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      if (adv) begin
        vld_r <= {vld_r[L-2:0], in_valid};
      end
    end
  end

  // clamp blend, form products
  always_comb begin
    t_ext = 33'(in_blend);
    if (t_ext < 0) begin
      t_c = '0;
    end else if (t_ext > 33'(ONE_Q14)) begin
      t_c = 15'(ONE_Q14);
    end else begin
      t_c = t_ext[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0]   <= {t_c, in_dst_w, in_dst_z, in_dst_y, in_dst_x,
                    in_src_w, in_src_z, in_src_y, in_src_x};
      prod_r[0] <= in_src_x * in_dst_x;
      prod_r[1] <= in_src_y * in_dst_y;
      prod_r[2] <= in_src_z * in_dst_z;
      prod_r[3] <= in_src_w * in_dst_w;
      for (int k = 1; k < ST_F; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // dot product, clamp, square, remainder
  always_comb begin
    dsum = DPW'(prod_r[0]) + DPW'(prod_r[1]) + DPW'(prod_r[2]) + DPW'(prod_r[3]);
    if (dsum > DPW'(ONE_Q28)) begin
      dclp = DPW'(ONE_Q28);
    end else if (dsum < -DPW'(ONE_Q28)) begin
      dclp = -DPW'(ONE_Q28);
    end else begin
      dclp = dsum;
    end
    sqf = dot_r[1] * dot_r[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r[1] <= 30'(dclp);
      for (int k = 2; k < ST_P; k++) begin
        dot_r[k] <= dot_r[k-1];
      end
      sq_r  <= sqf[SQW-1:0];
      rem_r <= (SQW'(1) << 56) - sq_r;
    end
  end

  assign v_w[0] = rem_r;
  assign r_w[0] = '0;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    qs_sqrt_cell #(.BITPOS(56 - 2 * i)) u_cell (
      .clk (clk),
      .en  (adv),
      .v_i (v_w[i]),
      .r_i (r_w[i]),
      .v_o (v_w[i+1]),
      .r_o (r_w[i+1])
    );
  end

  // quadrant fold for vectoring
  always_ff @(posedge clk) begin
    if (adv) begin
      if (dot_r[ST_P-1] < 0) begin
        p_r.x <= CW'(r_w[SQ_N][28:0]);
        p_r.y <= -CW'(dot_r[ST_P-1]);
        p_r.z <= ang_t'(HALF_PI_Q16);
      end else begin
        p_r.x <= CW'(dot_r[ST_P-1]);
        p_r.y <= CW'(r_w[SQ_N][28:0]);
        p_r.z <= '0;
      end
    end
  end

  assign vec_w[0] = p_r;

  for (genvar i = 0; i < C; i++) begin : g_vec
    qs_cordic_cell #(.STAGE(i), .VECTORING(1'b1)) u_cell (
      .clk (clk),
      .en  (adv),
      .c_i (vec_w[i]),
      .c_o (vec_w[i+1])
    );
  end

  // angle clamp and rounding, tolerance test, sine arguments
  always_comb begin
    zc = vec_w[C].z;
    if (zc < 0) begin
      zc = '0;
    end else if (zc > ang_t'(PI_Q16)) begin
      zc = ang_t'(PI_Q16);
    end
    near = (a_r <= 16'(tol_r)) || ((16'(PI_Q14) - a_r) <= 16'(tol_r));
    ta   = 18'((34'(pa_r) + 34'(8192)) >> 14);
    tb   = 18'((34'(pb_r) + 34'(8192)) >> 14);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= 16'((zc + ang_t'(2)) >>> 2);
      a16_r <= {a_r, 2'b00};
      pa_r  <= 33'(sd_r[ST_A][8*W +: 15]) * 33'({a_r, 2'b00});
      pb_r  <= 33'(15'(ONE_Q14) - sd_r[ST_A][8*W +: 15]) * 33'({a_r, 2'b00});
      rot0_r[0] <= '{x: CW'(GAIN_Q28), y: '0, z: fold(a16_r)};
      rot0_r[1] <= '{x: CW'(GAIN_Q28), y: '0, z: fold(tb)};
      rot0_r[2] <= '{x: CW'(GAIN_Q28), y: '0, z: fold(ta)};
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    assign rot_w[j][0] = rot0_r[j];
    for (genvar i = 0; i < C; i++) begin : g_rot
      qs_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_cell (
        .clk (clk),
        .en  (adv),
        .c_i (rot_w[j][i]),
        .c_o (rot_w[j][i+1])
      );
    end
  end

  // blend products, sum, magnitude with rounding, overflow check
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      neg_c[j] = num_r[j][PW];
      ovf_c[j] = nv_r[j] >= (NW'($unsigned(sa_v_r)) << W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_d_r <= rot_w[0][C].y;
      for (int j = 0; j < 4; j++) begin
        p0_r[j]  <= PW'(rot_w[1][C].y) * PW'($signed(sd_r[ST_D-1][j*W +: W]));
        p1_r[j]  <= PW'(rot_w[2][C].y) * PW'($signed(sd_r[ST_D-1][(4+j)*W +: W]));
        num_r[j] <= (PW+1)'(p0_r[j]) + (PW+1)'(p1_r[j]);
        nv_r[j]  <= NW'(num_r[j][PW] ? -num_r[j] : num_r[j])
                    + NW'($unsigned(sa_n_r) >> 1);
        dvr_r[j] <= nv_r[j];
      end
      sa_n_r <= sa_d_r;
      sa_v_r <= sa_n_r;
      sa_o_r <= sa_v_r;
    end
  end

  // status line: pass flag, signs, overflow
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[ST_M] <= '{pass: near, neg: '0, ovf: '0};
      for (int k = ST_M + 1; k < ST_F; k++) begin
        if (k == ST_D) begin
          st_r[k] <= '{pass: st_r[k-1].pass | (rot_w[0][C].y <= 0),
                       neg: st_r[k-1].neg, ovf: st_r[k-1].ovf};
        end else if (k == ST_V) begin
          st_r[k] <= '{pass: st_r[k-1].pass, neg: neg_c, ovf: st_r[k-1].ovf};
        end else if (k == ST_O) begin
          st_r[k] <= '{pass: st_r[k-1].pass, neg: st_r[k-1].neg, ovf: ovf_c};
        end else begin
          st_r[k] <= st_r[k-1];
        end
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_div
    assign drem_w[j][0] = dvr_r[j];
    assign ddvs_w[j][0] = $unsigned(sa_o_r);
    assign dq_w[j][0]   = '0;
    for (genvar i = 0; i < W; i++) begin : g_bit
      qs_div_cell #(.NW(NW), .QW(W), .SHIFT(W - 1 - i)) u_cell (
        .clk   (clk),
        .en    (adv),
        .rem_i (drem_w[j][i]),
        .dvs_i (ddvs_w[j][i]),
        .q_i   (dq_w[j][i]),
        .rem_o (drem_w[j][i+1]),
        .dvs_o (ddvs_w[j][i+1]),
        .q_o   (dq_w[j][i+1])
      );
    end
  end

  // select, saturate, hold result
  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r <= st_r[ST_F-1].pass;
      for (int j = 0; j < 4; j++) begin
        if (st_r[ST_F-1].pass) begin
          o_r[j] <= sd_r[ST_F-1][j*W +: W];
        end else if (!st_r[ST_F-1].neg[j]) begin
          if (st_r[ST_F-1].ovf[j] || dq_w[j][W] > {1'b0, {(W-1){1'b1}}}) begin
            o_r[j] <= {1'b0, {(W-1){1'b1}}};
          end else begin
            o_r[j] <= dq_w[j][W];
          end
        end else begin
          if (st_r[ST_F-1].ovf[j] || dq_w[j][W] > {1'b1, {(W-1){1'b0}}}) begin
            o_r[j] <= {1'b1, {(W-1){1'b0}}};
          end else begin
            o_r[j] <= -dq_w[j][W];
          end
        end
      end
    end
  end

  assign out_valid          = vld_r[L-1];
  assign out_x              = $signed(o_r[0]);
  assign out_y              = $signed(o_r[1]);
  assign out_z              = $signed(o_r[2]);
  assign out_w              = $signed(o_r[3]);
  assign out_passed_through = pt_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input held without a result waiting at the output");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_passed_through)))
    else $error("stalled result changed");

endmodule
